// File: design/gbb5_pkg.sv
package gbb5_pkg;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 14;
    localparam int ENTRY_W = 16;

    // Stream tdata layout: data byte, table index, table entry, zero pad to 40 bits
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [BYTE_W-1:0] GB_LEAD1_LO  = 8'hA1;
    localparam logic [BYTE_W-1:0] GB_LEAD1_HI  = 8'hA9;
    localparam logic [BYTE_W-1:0] GB_LEAD2_LO  = 8'hB0;
    localparam logic [BYTE_W-1:0] GB_LEAD2_HI  = 8'hF7;
    localparam logic [BYTE_W-1:0] HI_TRAIL_LO  = 8'hA1;
    localparam logic [BYTE_W-1:0] HI_TRAIL_HI  = 8'hFE;
    localparam logic [BYTE_W-1:0] B5_LEAD_LO   = 8'hA1;
    localparam logic [BYTE_W-1:0] B5_LEAD_HI   = 8'hF9;
    localparam logic [BYTE_W-1:0] B5_TRAIL_LO  = 8'h40;
    localparam logic [BYTE_W-1:0] B5_TRAIL_MID = 8'h7E;
    localparam logic [BYTE_W-1:0] GB_ZONE_GAP  = 8'd9;
    localparam logic [BYTE_W-1:0] B5_COL_GAP   = 8'd63;
    localparam logic [IDX_W-1:0]  GB_ROW_LEN   = 14'd94;
    localparam logic [IDX_W-1:0]  B5_ROW_LEN   = 14'd157;

    typedef enum logic {
        DIR_GB_TO_B5 = 1'b0,
        DIR_B5_TO_GB = 1'b1
    } dir_t;

    typedef enum logic {
        FUNC_DATA  = 1'b0,
        FUNC_TABLE = 1'b1
    } func_t;

    typedef enum logic {
        SEL_GB_TABLE = 1'b0,
        SEL_B5_TABLE = 1'b1
    } tsel_t;

    // One item waiting on the output side
    typedef struct packed {
        logic [BYTE_W-1:0] byte0;   // lead of a pair, or the lone byte
        logic [BYTE_W-1:0] byte1;   // trail of a pair
        logic              two;     // item produces two bytes
        logic              conv;    // pair replaced by a table entry
        tsel_t             sel;     // table that holds the entry
        logic              eob;
    } out_item_t;

    function automatic logic is_lead(input logic [BYTE_W-1:0] b, input dir_t dir);
        logic r;
        if (dir == DIR_GB_TO_B5) begin
            r = (b >= GB_LEAD1_LO && b <= GB_LEAD1_HI) || (b >= GB_LEAD2_LO && b <= GB_LEAD2_HI);
        end else begin
            r = b >= B5_LEAD_LO && b <= B5_LEAD_HI;
        end
        return r;
    endfunction

    function automatic logic is_trail(input logic [BYTE_W-1:0] b, input dir_t dir);
        logic r;
        if (dir == DIR_GB_TO_B5) begin
            r = b >= HI_TRAIL_LO && b <= HI_TRAIL_HI;
        end else begin
            r = (b >= B5_TRAIL_LO && b <= B5_TRAIL_MID) || (b >= HI_TRAIL_LO && b <= HI_TRAIL_HI);
        end
        return r;
    endfunction

endpackage

// File: design/gb_big5_pair_converter.sv
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: data_byte, table_index, table_entry;
//                                           tlast: end_of_buffer; tuser: func, table_select
// m_axis    out  m_axis_tvalid/tready       tdata: out_byte; tlast: buffer_end; tuser: run_last
// cfg       in   cfg_wr_en                  cfg_wr_data: direction
//
// An item is taken every cycle while m_axis keeps up; its result leaves from the output
// register. Lookups read one synchronous table port; the entry is registered as its pair
// enters the output register, which the pair holds for two beats. A lone byte that arrives
// meanwhile waits in a one-item spare register, so input keeps one item per cycle while
// m_axis keeps up. Reset clears the held lead, the direction and both output slots; the
// tables are undefined until loaded. Under an m_axis stall s_axis_tready drops once both
// slots are taken, or at once for a trail, which needs the output register itself.
module gb_big5_pair_converter
    import gbb5_pkg::*;
#(
    parameter int GB_TABLE_DEPTH   = 8192,
    parameter int BIG5_TABLE_DEPTH = 16384
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,     // direction

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,    // [7:0] data_byte, [21:8] table_index,
                                                  // [37:22] table_entry, [39:38] zero
    input  logic                 s_axis_tlast,    // end_of_buffer
    input  logic [1:0]           s_axis_tuser,    // [0] func, [1] table_select

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,    // [7:0] out_byte
    output logic                 m_axis_tlast,    // buffer_end
    output logic                 m_axis_tuser     // [0] run_last
);

    localparam int GB_AW = $clog2(GB_TABLE_DEPTH);
    localparam int B5_AW = $clog2(BIG5_TABLE_DEPTH);
    localparam logic [IDX_W:0] GB_LIMIT = (IDX_W+1)'(GB_TABLE_DEPTH);
    localparam logic [IDX_W:0] B5_LIMIT = (IDX_W+1)'(BIG5_TABLE_DEPTH);

    logic [ENTRY_W-1:0] gb_table_reg [GB_TABLE_DEPTH];
    logic [ENTRY_W-1:0] b5_table_reg [BIG5_TABLE_DEPTH];
    logic [ENTRY_W-1:0] gb_rd_reg;
    logic [ENTRY_W-1:0] b5_rd_reg;

    dir_t              direction_reg;
    logic [BYTE_W-1:0] held_lead_reg, held_lead_next;
    logic              lead_pending_reg, lead_pending_next;
    out_item_t         item_reg, item_next;
    logic              item_valid_reg, item_valid_next;
    logic              beat_reg, beat_next;
    out_item_t         spare_reg, spare_next;
    logic              spare_valid_reg, spare_valid_next;

    // input fields
    func_t              in_func;
    tsel_t              in_sel;
    logic [BYTE_W-1:0]  in_byte;
    logic [IDX_W-1:0]   in_tidx;
    logic [ENTRY_W-1:0] in_tentry;
    logic               in_eob;

    logic               accept;
    logic               out_fire;
    logic               last_beat;
    logic               main_done;
    logic               main_free;
    logic               spare_free;
    logic               emits;
    out_item_t          new_item;
    logic               lookup_ok;
    logic [BYTE_W-1:0]  gb_row;
    logic [BYTE_W-1:0]  b5_col;
    logic [IDX_W-1:0]   gb_idx;
    logic [IDX_W-1:0]   b5_idx;
    logic               gb_we, b5_we, gb_re, b5_re;
    logic [ENTRY_W-1:0] entry;

    assign in_byte   = s_axis_tdata[7:0];
    assign in_tidx   = s_axis_tdata[21:8];
    assign in_tentry = s_axis_tdata[37:22];
    assign in_eob    = s_axis_tlast;
    assign in_func   = func_t'(s_axis_tuser[0]);
    assign in_sel    = tsel_t'(s_axis_tuser[1]);

    assign last_beat  = !item_reg.two || beat_reg;
    assign out_fire   = item_valid_reg && m_axis_tready;
    assign main_done  = !item_valid_reg || (out_fire && last_beat);
    assign main_free  = main_done && !spare_valid_reg;
    assign spare_free = !spare_valid_reg || main_done;
    // a pair goes straight to the output register; a lone byte may wait in the spare
    assign s_axis_tready = lead_pending_reg ? main_free : spare_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Pair index for each direction; lead comes from the hold register
    always_comb begin
        if (held_lead_reg <= GB_LEAD1_HI) begin
            gb_row = held_lead_reg - GB_LEAD1_LO;
        end else begin
            gb_row = held_lead_reg - GB_LEAD2_LO + GB_ZONE_GAP;
        end
        if (in_byte <= B5_TRAIL_MID) begin
            b5_col = in_byte - B5_TRAIL_LO;
        end else begin
            b5_col = in_byte - HI_TRAIL_LO + B5_COL_GAP;
        end
        gb_idx = IDX_W'(gb_row) * GB_ROW_LEN + IDX_W'(in_byte - HI_TRAIL_LO);
        b5_idx = IDX_W'(held_lead_reg - B5_LEAD_LO) * B5_ROW_LEN + IDX_W'(b5_col);
    end

    always_comb begin
        lookup_ok = is_lead(held_lead_reg, direction_reg) && is_trail(in_byte, direction_reg);
        if (direction_reg == DIR_GB_TO_B5) begin
            lookup_ok = lookup_ok && ({1'b0, gb_idx} < GB_LIMIT);
        end else begin
            lookup_ok = lookup_ok && ({1'b0, b5_idx} < B5_LIMIT);
        end
    end

    // Reads and writes never share a cycle (one item per cycle), and a write
    // lands before the next item's read, so no forwarding is needed.
    assign gb_we = accept && in_func == FUNC_TABLE && in_sel == SEL_GB_TABLE
                   && ({1'b0, in_tidx} < GB_LIMIT);
    assign b5_we = accept && in_func == FUNC_TABLE && in_sel == SEL_B5_TABLE
                   && ({1'b0, in_tidx} < B5_LIMIT);
    assign gb_re = accept && in_func == FUNC_DATA && lead_pending_reg && lookup_ok
                   && direction_reg == DIR_GB_TO_B5;
    assign b5_re = accept && in_func == FUNC_DATA && lead_pending_reg && lookup_ok
                   && direction_reg == DIR_B5_TO_GB;

    always_ff @(posedge aclk) begin
        if (gb_we) begin
            gb_table_reg[in_tidx[GB_AW-1:0]] <= in_tentry;
        end
        if (gb_re) begin
            gb_rd_reg <= gb_table_reg[gb_idx[GB_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (b5_we) begin
            b5_table_reg[in_tidx[B5_AW-1:0]] <= in_tentry;
        end
        if (b5_re) begin
            b5_rd_reg <= b5_table_reg[b5_idx[B5_AW-1:0]];
        end
    end

    // Hold logic, output register and spare load
    always_comb begin
        held_lead_next    = held_lead_reg;
        lead_pending_next = lead_pending_reg;
        item_next         = item_reg;
        item_valid_next   = item_valid_reg;
        beat_next         = beat_reg;
        spare_next        = spare_reg;
        spare_valid_next  = spare_valid_reg;
        new_item          = '0;
        emits             = 1'b0;

        if (out_fire) begin
            if (last_beat) begin
                item_valid_next = 1'b0;
            end else begin
                beat_next = 1'b1;
            end
        end

        // spare moves up as the output register empties
        if (main_done && spare_valid_reg) begin
            item_next        = spare_reg;
            item_valid_next  = 1'b1;
            beat_next        = 1'b0;
            spare_valid_next = 1'b0;
        end

        if (accept && in_func == FUNC_DATA) begin
            if (lead_pending_reg) begin
                emits             = 1'b1;
                lead_pending_next = 1'b0;
                held_lead_next    = '0;
                new_item.byte0    = held_lead_reg;
                new_item.byte1    = in_byte;
                new_item.two      = 1'b1;
                new_item.conv     = lookup_ok;
            end else if (is_lead(in_byte, direction_reg) && !in_eob) begin
                held_lead_next    = in_byte;
                lead_pending_next = 1'b1;
            end else begin
                emits          = 1'b1;
                new_item.byte0 = in_byte;
                new_item.byte1 = in_byte;
                new_item.two   = 1'b0;
                new_item.conv  = 1'b0;
            end
            if (emits) begin
                new_item.sel = (direction_reg == DIR_GB_TO_B5) ? SEL_GB_TABLE : SEL_B5_TABLE;
                new_item.eob = in_eob;
                if (main_free) begin
                    item_next       = new_item;
                    item_valid_next = 1'b1;
                    beat_next       = 1'b0;
                end else begin
                    spare_next       = new_item;
                    spare_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg    <= DIR_GB_TO_B5;
            held_lead_reg    <= '0;
            lead_pending_reg <= 1'b0;
            item_valid_reg   <= 1'b0;
            beat_reg         <= 1'b0;
            spare_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                direction_reg <= dir_t'(cfg_wr_data);
            end
            held_lead_reg    <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
            item_valid_reg   <= item_valid_next;
            beat_reg         <= beat_next;
            spare_valid_reg  <= spare_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        spare_reg <= spare_next;
    end

    assign entry = (item_reg.sel == SEL_GB_TABLE) ? gb_rd_reg : b5_rd_reg;

    always_comb begin
        m_axis_tvalid = item_valid_reg;
        if (item_reg.two && !beat_reg) begin
            m_axis_tdata = item_reg.conv ? entry[15:8] : item_reg.byte0;
            m_axis_tlast = 1'b0;
            m_axis_tuser = 1'b0;
        end else begin
            if (item_reg.two) begin
                m_axis_tdata = item_reg.conv ? entry[7:0] : item_reg.byte1;
            end else begin
                m_axis_tdata = item_reg.byte0;
            end
            m_axis_tlast = item_reg.eob;
            m_axis_tuser = 1'b1;
        end
    end

endmodule
